>>> design/wsp_pkg.sv
// shared types and constants of the world-to-screen projection block
package wsp_pkg;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam int SIZE_W      = 14;
   localparam int CSR_INDEX_W = 1;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;

   localparam int POINT_FRAC = 8;
   localparam int NDC_FRAC   = 24;
   localparam int OUT_FRAC   = 8;
   localparam int CLIP_W     = 58;
   localparam int QUOT_W     = 48;
   localparam int MAG_W      = QUOT_W + 1;
   localparam int DIV_STAGES = QUOT_W;

   typedef logic signed [CLIP_W-1:0] clip_type;
   typedef logic [CLIP_W-1:0] umag_type;

endpackage

>>> design/wsp_if.sv
// item channel interfaces for requests and responses
interface wsp_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [3:0]  coef_index;
   logic signed [31:0] coef_value;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, operation, coef_index, coef_value, point_x, point_y,
                   point_z, input ready);
   modport sink (input valid, operation, coef_index, coef_value, point_x, point_y,
                 point_z, output ready);
endinterface

interface wsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        in_front;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;
   modport source (output valid, in_front, screen_x, screen_y, input ready);
   modport sink (input valid, in_front, screen_x, screen_y, output ready);
endinterface

>>> design/wsp_div.sv
// pipelined restoring divider, one quotient bit per stage
module wsp_div (
   input  logic                       clock,
   input  logic                       en,
   input  wsp_pkg::umag_type          num,
   input  wsp_pkg::umag_type          den,
   input  logic                       sat,
   output logic [wsp_pkg::MAG_W-1:0]  quot
);
   localparam int N = wsp_pkg::DIV_STAGES;
   localparam int W = wsp_pkg::CLIP_W;
   localparam int F = wsp_pkg::NDC_FRAC;

   logic [W-1:0]   r_ff   [N];
   logic [W-1:0]   b_ff   [N];
   logic [F-1:0]   a_ff   [N];
   logic [N-1:0]   q_ff   [N];
   logic           sat_ff [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         logic [W-1:0] r_prev;
         logic [W-1:0] b_prev;
         logic [F-1:0] a_prev;
         logic [N-1:0] q_prev;
         logic         s_prev;
         logic [W:0]   trial;
         logic [W:0]   diff;
         if (i == 0) begin : g_first
            assign r_prev = W'(num >> F);
            assign b_prev = den;
            assign a_prev = num[F-1:0];
            assign q_prev = '0;
            assign s_prev = sat;
         end else begin : g_next
            assign r_prev = r_ff[i-1];
            assign b_prev = b_ff[i-1];
            assign a_prev = a_ff[i-1];
            assign q_prev = q_ff[i-1];
            assign s_prev = sat_ff[i-1];
         end
         assign trial = {r_prev, a_prev[F-1]};
         assign diff  = trial - {1'b0, b_prev};
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[i]   <= diff[W] ? trial[W-1:0] : diff[W-1:0];
               q_ff[i]   <= {q_prev[N-2:0], ~diff[W]};
               a_ff[i]   <= {a_prev[F-2:0], 1'b0};
               b_ff[i]   <= b_prev;
               sat_ff[i] <= s_prev;
            end
         end
      end
   endgenerate

   assign quot = sat_ff[N-1] ? (wsp_pkg::MAG_W'(1) << N) : {1'b0, q_ff[N-1]};

endmodule

>>> design/world_to_screen_projection_top.sv
// top level of the world-to-screen projection block
// Projects points through a 4x4 matrix held in sixteen coefficient registers.
// req channel: an item with operation load writes coefficient coef_index at once
// and gives no response; an item with operation project gives one rsp item.
// csr port: index 0 is screen width, index 1 screen height, written while idle.
// One item is taken every cycle when the output is free or being taken.
// A project item's response is formed by these stages in order:
// four matrix, sum, test and range stages, the 48 stage divider that forms
// x/w and y/w, then two scale stages and the output register.
// A stall on rsp freezes the whole pipeline and req.ready falls with it,
// so nothing is dropped or repeated.
// Reset (synchronous) empties the pipeline, clears all coefficients to zero
// and sets the screen size to 1920 by 1080.
// A point with clip w below 0.1 returns in_front low with zero coordinates.
module world_to_screen_projection_top #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   wsp_req_if.sink                          req_ch,
   wsp_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [wsp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wsp_pkg::SIZE_W-1:0]       csr_wdata
);
   localparam int CW = wsp_pkg::CLIP_W;
   localparam int N  = wsp_pkg::DIV_STAGES;
   localparam int MW = wsp_pkg::MAG_W;

   logic en;
   logic accept;
   logic [wsp_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic signed [31:0] coef_ff [16];

   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;
   assign accept       = req_ch.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wsp_pkg::WIDTH_RESET;
         height_ff <= wsp_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wsp_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            wsp_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) coef_ff[i] <= '0;
      end else if (accept && req_ch.operation == wsp_pkg::OP_LOAD) begin
         coef_ff[req_ch.coef_index] <= req_ch.coef_value;
      end
   end

   // stage 1: products
   logic v1_ff;
   logic signed [63:0] prod_ff [9];
   logic signed [31:0] tx_ff, ty_ff, tw_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= accept && req_ch.operation == wsp_pkg::OP_PROJECT;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= coef_ff[0]  * req_ch.point_x;
         prod_ff[1] <= coef_ff[1]  * req_ch.point_y;
         prod_ff[2] <= coef_ff[2]  * req_ch.point_z;
         prod_ff[3] <= coef_ff[4]  * req_ch.point_x;
         prod_ff[4] <= coef_ff[5]  * req_ch.point_y;
         prod_ff[5] <= coef_ff[6]  * req_ch.point_z;
         prod_ff[6] <= coef_ff[12] * req_ch.point_x;
         prod_ff[7] <= coef_ff[13] * req_ch.point_y;
         prod_ff[8] <= coef_ff[14] * req_ch.point_z;
         tx_ff <= coef_ff[3];
         ty_ff <= coef_ff[7];
         tw_ff <= coef_ff[15];
      end
   end

   // stage 2: clip sums
   logic v2_ff;
   wsp_pkg::clip_type cx_ff, cy_ff, cw_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= CW'(prod_ff[0] >>> wsp_pkg::POINT_FRAC) + CW'(prod_ff[1] >>> wsp_pkg::POINT_FRAC)
                + CW'(prod_ff[2] >>> wsp_pkg::POINT_FRAC) + CW'(tx_ff);
         cy_ff <= CW'(prod_ff[3] >>> wsp_pkg::POINT_FRAC) + CW'(prod_ff[4] >>> wsp_pkg::POINT_FRAC)
                + CW'(prod_ff[5] >>> wsp_pkg::POINT_FRAC) + CW'(ty_ff);
         cw_ff <= CW'(prod_ff[6] >>> wsp_pkg::POINT_FRAC) + CW'(prod_ff[7] >>> wsp_pkg::POINT_FRAC)
                + CW'(prod_ff[8] >>> wsp_pkg::POINT_FRAC) + CW'(tw_ff);
      end
   end

   // stage 3: w test and magnitudes
   logic v3_ff, front3_ff, sx3_ff, sy3_ff;
   wsp_pkg::umag_type ax3_ff, ay3_ff, b3_ff;
   logic signed [CW+3:0] w10;
   assign w10 = (CW+4)'(cw_ff) * (CW+4)'(10);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         front3_ff <= w10 >= $signed((CW+4)'(1) << COEF_FRAC_BITS);
         sx3_ff    <= cx_ff[CW-1];
         sy3_ff    <= cy_ff[CW-1];
         ax3_ff    <= cx_ff[CW-1] ? CW'(-cx_ff) : CW'(cx_ff);
         ay3_ff    <= cy_ff[CW-1] ? CW'(-cy_ff) : CW'(cy_ff);
         b3_ff     <= CW'(cw_ff);
      end
   end

   // stage 4: integer part overflow
   logic v4_ff, front4_ff, sx4_ff, sy4_ff, ovx4_ff, ovy4_ff;
   wsp_pkg::umag_type ax4_ff, ay4_ff, b4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         front4_ff <= front3_ff;
         sx4_ff    <= sx3_ff;
         sy4_ff    <= sy3_ff;
         ovx4_ff   <= {24'd0, ax3_ff} >= {b3_ff, 24'd0};
         ovy4_ff   <= {24'd0, ay3_ff} >= {b3_ff, 24'd0};
         ax4_ff    <= ax3_ff;
         ay4_ff    <= ay3_ff;
         b4_ff     <= b3_ff;
      end
   end

   logic [MW-1:0] magx, magy;
   wsp_div u_div_x (.clock(clock), .en(en), .num(ax4_ff), .den(b4_ff), .sat(ovx4_ff),
                    .quot(magx));
   wsp_div u_div_y (.clock(clock), .en(en), .num(ay4_ff), .den(b4_ff), .sat(ovy4_ff),
                    .quot(magy));

   logic [N-1:0] dv_ff, dfront_ff, dsx_ff, dsy_ff;
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else if (en) dv_ff <= {dv_ff[N-2:0], v4_ff};
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dfront_ff <= {dfront_ff[N-2:0], front4_ff};
         dsx_ff    <= {dsx_ff[N-2:0], sx4_ff};
         dsy_ff    <= {dsy_ff[N-2:0], sy4_ff};
      end
   end

   // scale stages
   logic signed [14:0] kx, ky;
   logic [12:0] hw, hh;
   assign hw = width_ff[13:1];
   assign hh = height_ff[13:1];
   assign kx = $signed({2'b00, hw}) + 15'sd1;
   assign ky = 15'sd1 - $signed({2'b00, hh});

   logic m1v_ff, m1f_ff, m1sx_ff, m1sy_ff;
   logic signed [63:0] m1x_ff, m1y_ff;
   always_ff @(posedge clock) begin
      if (reset) m1v_ff <= 1'b0;
      else if (en) m1v_ff <= dv_ff[N-1];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m1f_ff  <= dfront_ff[N-1];
         m1sx_ff <= dsx_ff[N-1];
         m1sy_ff <= dsy_ff[N-1];
         m1x_ff  <= 64'(kx) * 64'($signed({1'b0, magx}));
         m1y_ff  <= 64'(ky) * 64'($signed({1'b0, magy}));
      end
   end

   logic m2v_ff, m2f_ff;
   logic signed [63:0] m2x_ff, m2y_ff;
   always_ff @(posedge clock) begin
      if (reset) m2v_ff <= 1'b0;
      else if (en) m2v_ff <= m1v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m2f_ff <= m1f_ff;
         m2x_ff <= m1sx_ff ? -m1x_ff : m1x_ff;
         m2y_ff <= m1sy_ff ? -m1y_ff : m1y_ff;
      end
   end

   function automatic logic signed [31:0] map_sat(input logic signed [63:0] p,
                                                  input logic [12:0] half);
      logic signed [63:0] s;
      s = (p >>> (wsp_pkg::NDC_FRAC - wsp_pkg::OUT_FRAC)) + 64'($signed({1'b0, half, 8'd0}));
      if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (s < -64'sh8000_0000) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   logic rsp_valid_ff, rsp_front_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= m2v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_front_ff <= m2f_ff;
         rsp_x_ff     <= m2f_ff ? map_sat(m2x_ff, hw) : '0;
         rsp_y_ff     <= m2f_ff ? map_sat(m2y_ff, hh) : '0;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.in_front = rsp_front_ff;
   assign rsp_ch.screen_x = rsp_x_ff;
   assign rsp_ch.screen_y = rsp_y_ff;

   a_load_no_item: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.operation == wsp_pkg::OP_LOAD) |=> !v1_ff)
      else $error("load item entered the pipeline");
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.in_front) |-> (rsp_ch.screen_x == 0 && rsp_ch.screen_y == 0))
      else $error("behind point with nonzero coordinates");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !v1_ff && dv_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
